// ===== design/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int BLOCKS_DEF = 4096;
	localparam int WORD_W     = 32;
	localparam int WORD_SH    = 5;
	localparam int BS_W       = 16;
	localparam int BIU_W      = 13;
	localparam int SIZE_W     = 32;
	localparam int CFG_W      = 16;

	localparam logic [BS_W-1:0]  BS_RESET  = 16'd512;
	localparam logic [BIU_W-1:0] BIU_RESET = 13'd4096;

	localparam logic CFG_BLOCK_SIZE    = 1'b0;
	localparam logic CFG_BLOCKS_IN_USE = 1'b1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_ALLOC  = 2'd0,
		ST_ZERO   = 2'd1,
		ST_NOROOM = 2'd2,
		ST_FREED  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DIV,
		S_CHK,
		S_SCAN_RD,
		S_SCAN_EV,
		S_MARK_RD,
		S_MARK_WR,
		S_FREE_RD,
		S_FREE_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic init_wr;
		logic load;
		logic div_step;
		logic chk;
		logic scan_ev;
		logic mark_wr;
		logic free_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic op_free;
		logic div_last;
		logic zero_size;
		logic too_big;
		logic start_oor;
		logic scan_hit;
		logic scan_last;
		logic mark_last;
		logic free_stop;
		logic out_free;
	} sts_t;

endpackage

// ===== design/bba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, divide, scan, mark and free walk.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   in_stall
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				// free requests skip the divide
				if (sts.op_free) begin
					state_d = S_CHK;
				end else begin
					cmd.div_step = 1'b1;
					if (sts.div_last) state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				if (sts.op_free) begin
					state_d = sts.start_oor ? S_DONE : S_FREE_RD;
				end else if (sts.zero_size || sts.too_big) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: state_d = S_SCAN_EV;
			S_SCAN_EV: begin
				cmd.scan_ev = 1'b1;
				if (sts.scan_hit) state_d = S_MARK_RD;
				else if (sts.scan_last) state_d = S_DONE;
				else state_d = S_SCAN_RD;
			end
			S_MARK_RD: state_d = S_MARK_WR;
			S_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				state_d = sts.mark_last ? S_DONE : S_MARK_RD;
			end
			S_FREE_RD: state_d = S_FREE_WR;
			S_FREE_WR: begin
				cmd.free_wr = 1'b1;
				state_d = sts.free_stop ? S_DONE : S_FREE_RD;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

endmodule

// ===== design/bba_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_dp
// Bitmaps, config registers, divider, word scan logic and result register.
// ----------------------------------------------------------------------------
module bba_dp import bba_pkg::*; #(
	parameter int NUM_BLOCKS = BLOCKS_DEF,
	parameter int IDX_W      = $clog2(NUM_BLOCKS),
	parameter int CNT_W      = IDX_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              op,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic [IDX_W-1:0]  start_block,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  block_index,
	output logic [CNT_W-1:0]  block_count
);

	localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int PW        = WA_W + WORD_SH + 1;
	localparam int LW        = (PW > BIU_W) ? PW : BIU_W;
	localparam int DIV_N     = SIZE_W;

	// config
	logic [BS_W-1:0]  bs_cfg_q;
	logic [BIU_W-1:0] biu_cfg_q;

	// memories
	logic [WORD_W-1:0] free_mem  [NUM_WORDS];
	logic [WORD_W-1:0] start_mem [NUM_WORDS];
	logic [WORD_W-1:0] free_rd_q, start_rd_q;
	logic [WORD_W-1:0] free_wd, start_wd;
	logic              free_we, start_we;

	// control registers
	logic [WA_W-1:0]  word_q;
	logic [4:0]       dcnt_q;
	logic             hit_q;
	logic             out_valid_q;

	// payload registers
	logic              op_q;
	logic [SIZE_W-1:0] size_q;
	logic [PW-1:0]     start_q;
	logic [PW-1:0]     lim_q;
	logic [BS_W-1:0]   bs_q;
	logic [BS_W-1:0]   rem_q;
	logic [SIZE_W-1:0] quo_q;
	logic [PW-1:0]     need_q;
	logic [PW-1:0]     first_q;
	logic [PW-1:0]     stop_q;
	logic [1:0]        status_q;
	logic [IDX_W-1:0]  index_q;
	logic [CNT_W-1:0]  count_q;

	// combinational
	logic [LW-1:0]     biu_ext, lim_full;
	logic [BS_W:0]     rem_sh, rem_sub;
	logic              q_bit;
	logic [SIZE_W:0]   need_full;
	logic [PW-1:0]     base, word_end;
	logic [WORD_W-1:0] f_eff;
	logic              hz [6][WORD_W];
	logic [4:0]        zi [6][WORD_W];
	logic [PW-1:0]     first_k [WORD_W];
	logic [WORD_W-1:0] hit_v;
	logic              any_hit;
	logic [PW-1:0]     win_first;
	logic [PW-1:0]     run_end;
	logic [WORD_W-1:0] mark_mask, start_bit;
	logic [WORD_W-1:0] stop_v, free_mask;
	logic              any_stop;
	logic [PW-1:0]     stop_pos;
	logic [PW-1:0]     pos_k [WORD_W];
	status_t           res_st;

	assign biu_ext  = LW'(biu_cfg_q);
	assign lim_full = (biu_ext > LW'(NUM_BLOCKS)) ? LW'(NUM_BLOCKS) : biu_ext;

	// restoring divide, one quotient bit per cycle
	assign rem_sh  = {rem_q, quo_q[SIZE_W-1]};
	assign rem_sub = rem_sh - {1'b0, bs_q};
	assign q_bit   = (rem_sh >= {1'b0, bs_q});
	assign need_full = {1'b0, quo_q} + (SIZE_W+1)'(rem_q != '0);

	assign base     = PW'(word_q) << WORD_SH;
	assign word_end = base + PW'(WORD_W);
	assign run_end  = first_q + need_q;

	// scan: index of last used block at or below each bit, log-depth prefix
	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			pos_k[k] = base + PW'(k);
			f_eff[k] = free_rd_q[k] && (pos_k[k] < lim_q);
			hz[0][k] = !f_eff[k];
			zi[0][k] = 5'(k);
		end
		for (int l = 0; l < 5; l++) begin
			for (int k = 0; k < WORD_W; k++) begin
				hz[l+1][k] = hz[l][k];
				zi[l+1][k] = zi[l][k];
				if (k >= (1 << l)) begin
					if (!hz[l][k]) begin
						hz[l+1][k] = hz[l][k - (1 << l)];
						zi[l+1][k] = zi[l][k - (1 << l)];
					end
				end
			end
		end
		for (int k = 0; k < WORD_W; k++) begin
			first_k[k] = hz[5][k] ? (base + PW'(zi[5][k]) + PW'(1)) : first_q;
			hit_v[k]   = (pos_k[k] + PW'(1)) >= (first_k[k] + need_q);
		end
		any_hit   = 1'b0;
		win_first = first_q;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (hit_v[k]) begin
				any_hit   = 1'b1;
				win_first = first_k[k];
			end
		end
	end

	// mark and free-walk masks
	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			mark_mask[k] = (pos_k[k] >= first_q) && (pos_k[k] < run_end);
			start_bit[k] = (pos_k[k] == first_q);
			stop_v[k]    = ((pos_k[k] > start_q) && start_rd_q[k]) || (pos_k[k] >= lim_q);
		end
		any_stop = 1'b0;
		stop_pos = lim_q;
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (stop_v[k]) begin
				any_stop = 1'b1;
				stop_pos = pos_k[k];
			end
		end
		for (int k = 0; k < WORD_W; k++) begin
			free_mask[k] = (pos_k[k] >= start_q) && (pos_k[k] < stop_pos);
		end
	end

	always_comb begin
		free_we  = cmd.init_wr || cmd.mark_wr || cmd.free_wr;
		start_we = cmd.init_wr || cmd.mark_wr;
		free_wd  = '1;
		start_wd = '1;
		if (cmd.mark_wr) begin
			free_wd  = free_rd_q & ~mark_mask;
			start_wd = (start_rd_q & ~mark_mask) | start_bit;
		end else if (cmd.free_wr) begin
			free_wd  = free_rd_q | free_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (free_we) free_mem[word_q] <= free_wd;
		if (start_we) start_mem[word_q] <= start_wd;
		free_rd_q  <= free_mem[word_q];
		start_rd_q <= start_mem[word_q];
	end

	always_comb begin
		if (op_q == OP_FREE) res_st = ST_FREED;
		else if (size_q == '0) res_st = ST_ZERO;
		else if (hit_q) res_st = ST_ALLOC;
		else res_st = ST_NOROOM;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_cfg_q    <= BS_RESET;
			biu_cfg_q   <= BIU_RESET;
			word_q      <= '0;
			dcnt_q      <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_BLOCK_SIZE) bs_cfg_q <= cfg_wdata[BS_W-1:0];
				else biu_cfg_q <= cfg_wdata[BIU_W-1:0];
			end
			if (cmd.init_wr) word_q <= word_q + WA_W'(1);
			if (cmd.load) begin
				word_q <= (op == OP_FREE) ? WA_W'(start_block >> WORD_SH) : '0;
				dcnt_q <= '0;
				hit_q  <= 1'b0;
			end
			if (cmd.div_step) dcnt_q <= dcnt_q + 5'd1;
			if (cmd.scan_ev) begin
				if (any_hit) begin
					hit_q  <= 1'b1;
					word_q <= win_first[WA_W+WORD_SH-1:WORD_SH];
				end else begin
					word_q <= word_q + WA_W'(1);
				end
			end
			if (cmd.mark_wr) word_q <= word_q + WA_W'(1);
			if (cmd.free_wr) word_q <= word_q + WA_W'(1);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			size_q  <= size_bytes;
			quo_q   <= size_bytes;
			rem_q   <= '0;
			start_q <= PW'(start_block);
			stop_q  <= PW'(start_block);
			first_q <= '0;
			lim_q   <= PW'(lim_full);
			bs_q    <= (bs_cfg_q == '0) ? BS_W'(1) : bs_cfg_q;
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? rem_sub[BS_W-1:0] : rem_sh[BS_W-1:0];
			quo_q <= {quo_q[SIZE_W-2:0], q_bit};
		end
		if (cmd.chk) need_q <= need_full[PW-1:0];
		if (cmd.scan_ev) first_q <= any_hit ? win_first : first_k[WORD_W-1];
		if (cmd.free_wr && (any_stop || (word_end >= lim_q))) stop_q <= stop_pos;
		if (cmd.out_load) begin
			status_q <= res_st;
			index_q  <= (res_st == ST_ALLOC) ? first_q[IDX_W-1:0] : '0;
			if (res_st == ST_ALLOC) count_q <= need_q[CNT_W-1:0];
			else if (res_st == ST_FREED) count_q <= CNT_W'(stop_q - start_q);
			else count_q <= '0;
		end
	end

	always_comb begin
		sts.init_last = (word_q == WA_W'(NUM_WORDS - 1));
		sts.op_free   = (op_q == OP_FREE);
		sts.div_last  = (dcnt_q == 5'(DIV_N - 1));
		sts.zero_size = (size_q == '0);
		sts.too_big   = (need_full > (SIZE_W+1)'(lim_q));
		sts.start_oor = (start_q >= lim_q);
		sts.scan_hit  = any_hit;
		sts.scan_last = (word_end >= lim_q);
		sts.mark_last = (word_end >= run_end);
		sts.free_stop = any_stop || (word_end >= lim_q);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign block_index = index_q;
	assign block_count = count_q;

endmodule

// ===== design/bitmap_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a free bitmap and a run-start bitmap.
// ----------------------------------------------------------------------------
// Allocate: divide, size check, a read and an evaluate per scanned 32-block
//   word, a read and a write per marked word, then the result register.
// Free: start check, a read and a write per walked word, then the result.
//   One request in flight at a time, over a word-serial bitmap port.
// Reset: asynchronous, active low. After reset a clearing pass
//   sets both bitmaps to all ones; no request is taken
//   until it ends. Config writes are taken at any time.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core import bba_pkg::*; #(
	parameter int NUM_BLOCKS = BLOCKS_DEF,
	parameter int IDX_W      = $clog2(NUM_BLOCKS),
	parameter int CNT_W      = IDX_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	// config port
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic [IDX_W-1:0]  start_block,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  block_index,
	output logic [CNT_W-1:0]  block_count
);

	// controller and datapath talk only through these two bundles
	cmd_t cmd;
	sts_t sts;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// datapath: bitmaps (one 32-bit word per access), divider, scan masks,
	// and the result register that decouples the output side
	bba_dp #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.IDX_W      (IDX_W),
		.CNT_W      (CNT_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.op          (op),
		.size_bytes  (size_bytes),
		.start_block (start_block),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.block_index (block_index),
		.block_count (block_count)
	);

endmodule

// ===== design/bba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the block allocator.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; #(
	parameter int IDX_W = 12,
	parameter int CNT_W = 13
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [1:0]       status,
	input logic [IDX_W-1:0] block_index,
	input logic [CNT_W-1:0] block_count
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(block_index) && $stable(block_count))
		else $error("result changed while stalled");

	// one request at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_ALLOC) |-> block_index == '0)
		else $error("index set on non-allocate result");

	a_fail_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_ZERO) || (status == ST_NOROOM)) |-> block_count == '0)
		else $error("count set on failed allocate");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ALLOC) |-> block_count != '0)
		else $error("empty grant");

endmodule

bind bitmap_block_allocator_core bba_checker #(
	.IDX_W (IDX_W),
	.CNT_W (CNT_W)
) u_bba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.block_index (block_index),
	.block_count (block_count)
);
